// ----- rtl/opr_pkg.sv -----
// package with constants, codes and types of the octilinear polyline rasterizer
package opr_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int EXT_W    = 7;
  localparam int CRD_W    = 11;
  localparam int CNT_W    = 16;
  localparam int IDX_W    = 2;

  localparam logic [IDX_W-1:0] REG_GRID_ROWS = 2'd0;
  localparam logic [IDX_W-1:0] REG_GRID_COLS = 2'd1;

  localparam logic KIND_ROW = 1'b0;
  localparam logic KIND_ERR = 1'b1;

  localparam logic [EXT_W-1:0] EXT_MAX_ROWS = EXT_W'(MAX_ROWS);
  localparam logic [EXT_W-1:0] EXT_MAX_COLS = EXT_W'(MAX_COLS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAW,
    ST_READ
  } state_e;

  typedef logic [MAX_COLS-1:0] row_t;

endpackage

// ----- rtl/octilinear_polyline_raster.sv -----
// top level of the octilinear polyline rasterizer with its bitmap memory
//
//  channel   | signals                                        | flow
//  ----------+------------------------------------------------+----------------------
//  request   | start, busy, mode_i, first_of_line_i, x_i, y_i | in, taken on start & !busy
//  config    | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i | in, ready always high
//  result    | res_valid_o, kind_o, row_bits_o, row_index_o,  | out, one-cycle strobe
//            | polyline_number_o, point_number_o, last_o      |
//
// a first vertex leaves the block idle; a drawn segment visits in turn each bitmap row
// it touches (at most the row count, a horizontal one touches one), one memory read per row
// a failing vertex gives its error result in the cycle after the request is taken
// in a finish, rows come one per cycle from the highest row index down to row 0;
// a finish after an error gives no rows and only clears the frame
// reset clears all per-row valid bits at once, so the bitmap needs no clearing pass
// results cannot be stalled
module octilinear_polyline_raster (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          mode_i,
  input  logic                          first_of_line_i,
  input  logic signed [opr_pkg::CRD_W-1:0] x_i,
  input  logic signed [opr_pkg::CRD_W-1:0] y_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [opr_pkg::IDX_W-1:0]     cfg_index_i,
  input  logic [opr_pkg::EXT_W-1:0]     cfg_data_i,
  output logic                          res_valid_o,
  output logic                          kind_o,
  output logic [opr_pkg::MAX_COLS-1:0]  row_bits_o,
  output logic [opr_pkg::ROW_W-1:0]     row_index_o,
  output logic [opr_pkg::CNT_W-1:0]     polyline_number_o,
  output logic [opr_pkg::CNT_W-1:0]     point_number_o,
  output logic                          last_o
);
  import opr_pkg::*;

  localparam int D_W = CRD_W + 1;

  state_e state_q, state_d;

  logic [EXT_W-1:0] rows_q, cols_q;
  logic [EXT_W-1:0] rows_eff, cols_eff;

  logic signed [CRD_W-1:0] prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  logic                    err_q, err_d;
  logic [CNT_W-1:0]        line_q, line_d, pt_q, pt_d;

  logic [COL_W-1:0]  cur_x_q, cur_x_d;
  logic [ROW_W-1:0]  cur_y_q, cur_y_d;
  logic signed [1:0] step_x_q, step_x_d, step_y_q, step_y_d;
  logic [CRD_W-1:0]  remain_q, remain_d;
  logic              horiz_q, horiz_d;
  row_t              hmask_q, hmask_d;

  logic              wr_pend_q, wr_pend_d;
  logic [ROW_W-1:0]  wr_row_q, wr_row_d;
  row_t              wr_mask_q, wr_mask_d;

  row_t              bitmap_mem [MAX_ROWS];
  row_t              rd_q;
  logic              rv_q;
  logic [MAX_ROWS-1:0] row_vld_q;
  logic              clear_all;
  logic              rd_en;
  logic [ROW_W-1:0]  rd_addr;
  row_t              rd_row;

  logic [ROW_W-1:0]  rd_cnt_q, rd_cnt_d;
  logic              rdo_pend_q, rdo_pend_d;
  logic [ROW_W-1:0]  rdo_row_q, rdo_row_d;
  logic              rdo_last_q, rdo_last_d;

  logic              res_valid_q, res_valid_d;
  logic              kind_q, kind_d;
  row_t              bits_q, bits_d;
  logic [ROW_W-1:0]  ridx_q, ridx_d;
  logic [CNT_W-1:0]  pln_q, pln_d, ptn_q, ptn_d;
  logic              last_q, last_d;

  logic accept;
  logic signed [D_W-1:0] xs, ys, pxs, pys, dx, dy, ax, ay;
  logic [CRD_W-1:0] n_len;
  logic in_grid, dir_ok;
  logic [COL_W-1:0] lo, hi;
  logic [CNT_W-1:0] pt_inc, line_inc;
  logic signed [EXT_W:0] nx, ny;
  logic draw_done;
  row_t col_mask;

  assign rows_eff = (rows_q == '0) ? EXT_W'(1) :
                    (rows_q > EXT_MAX_ROWS) ? EXT_MAX_ROWS : rows_q;
  assign cols_eff = (cols_q == '0) ? EXT_W'(1) :
                    (cols_q > EXT_MAX_COLS) ? EXT_MAX_COLS : cols_q;
  assign col_mask = {MAX_COLS{1'b1}} >> (EXT_MAX_COLS - cols_eff);

  assign accept      = start && !busy;
  assign busy        = (state_q != ST_IDLE) || rdo_pend_q;
  assign cfg_ready_o = 1'b1;

  // vertex checks
  assign xs  = D_W'(x_i);
  assign ys  = D_W'(y_i);
  assign pxs = D_W'(prev_x_q);
  assign pys = D_W'(prev_y_q);
  assign dx  = xs - pxs;
  assign dy  = ys - pys;
  assign ax  = dx[D_W-1] ? -dx : dx;
  assign ay  = dy[D_W-1] ? -dy : dy;
  assign n_len = (ax > ay) ? ax[CRD_W-1:0] : ay[CRD_W-1:0];
  assign in_grid = !xs[D_W-1] && (xs < $signed(D_W'(cols_eff))) &&
                   !ys[D_W-1] && (ys < $signed(D_W'(rows_eff)));
  assign dir_ok  = (dx == '0) || (dy == '0) || (dx == dy) || (dx == -dy);
  assign pt_inc   = (pt_q == '1) ? pt_q : pt_q + CNT_W'(1);
  assign line_inc = (line_q == '1) ? line_q : line_q + CNT_W'(1);

  // horizontal span, clipped to the grid
  always_comb begin
    if (dx[D_W-1] == 1'b0 && dx != '0) begin
      lo = pxs[D_W-1] ? '0 : prev_x_q[COL_W-1:0];
      hi = x_i[COL_W-1:0];
    end else begin
      lo = x_i[COL_W-1:0];
      hi = (pxs >= $signed(D_W'(cols_eff))) ? COL_W'(cols_eff - EXT_W'(1))
                                             : prev_x_q[COL_W-1:0];
    end
  end

  assign nx = $signed({2'b00, cur_x_q}) + (EXT_W+1)'(step_x_q);
  assign ny = $signed({2'b00, cur_y_q}) + (EXT_W+1)'(step_y_q);
  assign draw_done = (remain_q == '0) ||
                     nx[EXT_W] || (nx[EXT_W-1:0] >= cols_eff) ||
                     ny[EXT_W] || (ny[EXT_W-1:0] >= rows_eff);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (mode_i) begin
            if (!err_q) state_d = ST_READ;
          end else if (!first_of_line_i && !err_q && in_grid && dir_ok) begin
            state_d = ST_DRAW;
          end
        end
      end
      ST_DRAW: begin
        if (horiz_q || draw_done) state_d = ST_IDLE;
      end
      ST_READ: begin
        if (rd_cnt_q == '0) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    prev_x_d = prev_x_q;
    prev_y_d = prev_y_q;
    err_d    = err_q;
    line_d   = line_q;
    pt_d     = pt_q;
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    step_x_d = step_x_q;
    step_y_d = step_y_q;
    remain_d = remain_q;
    horiz_d  = horiz_q;
    hmask_d  = hmask_q;
    wr_pend_d = 1'b0;
    wr_row_d  = wr_row_q;
    wr_mask_d = wr_mask_q;
    rd_en     = 1'b0;
    rd_addr   = cur_y_q;
    rd_cnt_d  = rd_cnt_q;
    rdo_pend_d = 1'b0;
    rdo_row_d  = rdo_row_q;
    rdo_last_d = rdo_last_q;
    clear_all  = 1'b0;
    res_valid_d = 1'b0;
    kind_d = kind_q;
    bits_d = bits_q;
    ridx_d = ridx_q;
    pln_d  = pln_q;
    ptn_d  = ptn_q;
    last_d = last_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (mode_i) begin
            rd_cnt_d = ROW_W'(rows_eff - EXT_W'(1));
            if (err_q) clear_all = 1'b1;
          end else if (first_of_line_i) begin
            line_d   = line_inc;
            pt_d     = CNT_W'(1);
            prev_x_d = x_i;
            prev_y_d = y_i;
          end else begin
            pt_d = pt_inc;
            if (!err_q) begin
              prev_x_d = x_i;
              prev_y_d = y_i;
              if (!(in_grid && dir_ok)) begin
                err_d       = 1'b1;
                res_valid_d = 1'b1;
                kind_d      = KIND_ERR;
                bits_d      = '0;
                ridx_d      = '0;
                pln_d       = line_q;
                ptn_d       = pt_inc;
                last_d      = 1'b1;
              end else begin
                cur_x_d  = x_i[COL_W-1:0];
                cur_y_d  = y_i[ROW_W-1:0];
                step_x_d = (dx == '0) ? 2'sd0 : (dx[D_W-1] ? 2'sd1 : -2'sd1);
                step_y_d = (dy == '0) ? 2'sd0 : (dy[D_W-1] ? 2'sd1 : -2'sd1);
                remain_d = n_len;
                horiz_d  = (dy == '0);
                hmask_d  = ({MAX_COLS{1'b1}} << lo) &
                           ({MAX_COLS{1'b1}} >> (COL_W'(MAX_COLS - 1) - hi));
              end
            end
          end
        end
      end
      ST_DRAW: begin
        rd_en     = 1'b1;
        rd_addr   = cur_y_q;
        wr_pend_d = 1'b1;
        wr_row_d  = cur_y_q;
        wr_mask_d = horiz_q ? hmask_q : (row_t'(1) << cur_x_q);
        if (!(horiz_q || draw_done)) begin
          cur_x_d  = nx[COL_W-1:0];
          cur_y_d  = ny[ROW_W-1:0];
          remain_d = remain_q - CRD_W'(1);
        end
      end
      ST_READ: begin
        rd_en      = 1'b1;
        rd_addr    = rd_cnt_q;
        rdo_pend_d = 1'b1;
        rdo_row_d  = rd_cnt_q;
        rdo_last_d = (rd_cnt_q == '0);
        if (rd_cnt_q == '0) clear_all = 1'b1;
        else rd_cnt_d = rd_cnt_q - ROW_W'(1);
      end
      default: ;
    endcase

    if (clear_all) begin
      prev_x_d = '0;
      prev_y_d = '0;
      err_d    = 1'b0;
      line_d   = '0;
      pt_d     = '0;
    end

    if (rdo_pend_q) begin
      res_valid_d = 1'b1;
      kind_d      = KIND_ROW;
      bits_d      = rd_row & col_mask;
      ridx_d      = rdo_row_q;
      pln_d       = '0;
      ptn_d       = '0;
      last_d      = rdo_last_q;
    end
  end

  assign rd_row = rv_q ? rd_q : '0;

  // bitmap memory, one read and one write port
  always_ff @(posedge clk_i) begin
    if (wr_pend_q) bitmap_mem[wr_row_q] <= rd_row | wr_mask_q;
    if (rd_en) begin
      rd_q <= bitmap_mem[rd_addr];
      rv_q <= row_vld_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
    end else begin
      if (wr_pend_q) row_vld_q[wr_row_q] <= 1'b1;
      if (clear_all) row_vld_q <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rows_q      <= EXT_MAX_ROWS;
      cols_q      <= EXT_MAX_COLS;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      err_q       <= 1'b0;
      line_q      <= '0;
      pt_q        <= '0;
      wr_pend_q   <= 1'b0;
      rdo_pend_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prev_x_q    <= prev_x_d;
      prev_y_q    <= prev_y_d;
      err_q       <= err_d;
      line_q      <= line_d;
      pt_q        <= pt_d;
      wr_pend_q   <= wr_pend_d;
      rdo_pend_q  <= rdo_pend_d;
      res_valid_q <= res_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_GRID_ROWS: rows_q <= cfg_data_i;
          REG_GRID_COLS: cols_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_x_q    <= cur_x_d;
    cur_y_q    <= cur_y_d;
    step_x_q   <= step_x_d;
    step_y_q   <= step_y_d;
    remain_q   <= remain_d;
    horiz_q    <= horiz_d;
    hmask_q    <= hmask_d;
    wr_row_q   <= wr_row_d;
    wr_mask_q  <= wr_mask_d;
    rd_cnt_q   <= rd_cnt_d;
    rdo_row_q  <= rdo_row_d;
    rdo_last_q <= rdo_last_d;
    kind_q     <= kind_d;
    bits_q     <= bits_d;
    ridx_q     <= ridx_d;
    pln_q      <= pln_d;
    ptn_q      <= ptn_d;
    last_q     <= last_d;
  end

  assign res_valid_o       = res_valid_q;
  assign kind_o            = kind_q;
  assign row_bits_o        = bits_q;
  assign row_index_o       = ridx_q;
  assign polyline_number_o = pln_q;
  assign point_number_o    = ptn_q;
  assign last_o            = last_q;

  // read never hits the row whose write-back is still pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en && wr_pend_q |-> rd_addr != wr_row_q)
    else $error("read of a row with a pending write");

  // drawing only addresses rows inside the grid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DRAW |-> {1'b0, cur_y_q} < rows_eff)
    else $error("draw row outside grid");

  // an error report leaves the error flag set and is marked last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && kind_o == KIND_ERR |-> err_q && last_o)
    else $error("error report without error flag");

  // no request is taken while a readout row is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rdo_pend_q |-> busy)
    else $error("request taken while readout in flight");

endmodule

// ----- tb/tb_octilinear_polyline_raster.sv -----
// self-checking testbench for the octilinear polyline rasterizer
module tb_octilinear_polyline_raster;
  import opr_pkg::*;

  localparam logic OP_VERTEX = 1'b0;
  localparam logic OP_FINISH = 1'b1;
  localparam int   DRAIN_CYCLES = 80;
  localparam int   NUM_PHASES = 7;
  localparam int   ITEMS_PER_PHASE = 60;

  class raster_scoreboard;
    typedef struct {
      logic             kind;
      row_t             bits;
      logic [ROW_W-1:0] row;
      logic [CNT_W-1:0] line;
      logic [CNT_W-1:0] point;
      logic             last;
    } raster_result_t;

    raster_result_t awaited[$];
    row_t           bitmap[MAX_ROWS];
    logic [EXT_W-1:0] rows_reg;
    logic [EXT_W-1:0] cols_reg;
    int  prev_x;
    int  prev_y;
    bit  err_flag;
    int  line_cnt;
    int  point_cnt;
    int  mismatches;
    int  requests;
    int  rows_seen;
    int  reports_seen;

    function new();
      clear_frame();
      rows_reg = EXT_MAX_ROWS;
      cols_reg = EXT_MAX_COLS;
    endfunction

    function void clear_frame();
      foreach (bitmap[r]) bitmap[r] = '0;
      prev_x = 0;
      prev_y = 0;
      err_flag = 1'b0;
      line_cnt = 0;
      point_cnt = 0;
    endfunction

    function int rows_eff();
      if (rows_reg == 0) return 1;
      if (rows_reg > MAX_ROWS) return MAX_ROWS;
      return int'(rows_reg);
    endfunction

    function int cols_eff();
      if (cols_reg == 0) return 1;
      if (cols_reg > MAX_COLS) return MAX_COLS;
      return int'(cols_reg);
    endfunction

    function int bump(int v);
      return (v < 65535) ? v + 1 : 65535;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void write_register(logic [IDX_W-1:0] idx, logic [EXT_W-1:0] data);
      if (idx == REG_GRID_ROWS) rows_reg = data;
      else if (idx == REG_GRID_COLS) cols_reg = data;
    endfunction

    function void plot_segment(int x1, int y1, int rows, int cols);
      int dx, dy, sx, sy, ax, ay, n, cx, cy;
      dx = x1 - prev_x;
      dy = y1 - prev_y;
      sx = (dx > 0) ? 1 : ((dx < 0) ? -1 : 0);
      sy = (dy > 0) ? 1 : ((dy < 0) ? -1 : 0);
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      n = (ax > ay) ? ax : ay;
      for (int k = 0; k <= n; k++) begin
        cx = prev_x + k * sx;
        cy = prev_y + k * sy;
        if (cx >= 0 && cx < cols && cy >= 0 && cy < rows) bitmap[cy][cx] = 1'b1;
      end
    endfunction

    function void note_request(logic mode, logic first, logic signed [CRD_W-1:0] x,
                               logic signed [CRD_W-1:0] y);
      int xs, ys, rows, cols, dx, dy;
      row_t mask;
      raster_result_t res;
      requests++;
      xs = x;
      ys = y;
      rows = rows_eff();
      cols = cols_eff();
      if (mode == OP_FINISH) begin
        if (!err_flag) begin
          mask = (cols >= MAX_COLS) ? '1 : (row_t'(1) << cols) - row_t'(1);
          for (int r = rows - 1; r >= 0; r--) begin
            res.kind  = KIND_ROW;
            res.bits  = bitmap[r] & mask;
            res.row   = ROW_W'(r);
            res.line  = '0;
            res.point = '0;
            res.last  = (r == 0);
            awaited.push_back(res);
          end
        end
        clear_frame();
        return;
      end
      if (first) begin
        line_cnt = bump(line_cnt);
        point_cnt = 1;
        prev_x = xs;
        prev_y = ys;
        return;
      end
      point_cnt = bump(point_cnt);
      if (err_flag) return;
      dx = xs - prev_x;
      dy = ys - prev_y;
      if (xs < 0 || xs >= cols || ys < 0 || ys >= rows ||
          !(dx == 0 || dy == 0 || dx == dy || dx == -dy)) begin
        err_flag  = 1'b1;
        res.kind  = KIND_ERR;
        res.bits  = '0;
        res.row   = '0;
        res.line  = CNT_W'(line_cnt);
        res.point = CNT_W'(point_cnt);
        res.last  = 1'b1;
        awaited.push_back(res);
      end else begin
        plot_segment(xs, ys, rows, cols);
      end
      prev_x = xs;
      prev_y = ys;
    endfunction

    function void check_result(logic kind, row_t bits, logic [ROW_W-1:0] row,
                               logic [CNT_W-1:0] line, logic [CNT_W-1:0] point, logic last);
      raster_result_t want;
      if (kind == KIND_ERR) reports_seen++;
      else rows_seen++;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d row %0d bits %h line %0d point %0d last %0d",
                   kind, row, bits, line, point, last);
        return;
      end
      want = awaited.pop_front();
      if (want.kind !== kind || want.bits !== bits || want.row !== row ||
          want.line !== line || want.point !== point || want.last !== last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch exp: kind %0d row %0d bits %h line %0d point %0d last %0d",
                   want.kind, want.row, want.bits, want.line, want.point, want.last);
          $display("         got: kind %0d row %0d bits %h line %0d point %0d last %0d",
                   kind, row, bits, line, point, last);
        end
      end
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic                    mode_i;
  logic                    first_of_line_i;
  logic signed [CRD_W-1:0] x_i;
  logic signed [CRD_W-1:0] y_i;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [IDX_W-1:0]        cfg_index_i;
  logic [EXT_W-1:0]        cfg_data_i;
  logic                    res_valid_o;
  logic                    kind_o;
  logic [MAX_COLS-1:0]     row_bits_o;
  logic [ROW_W-1:0]        row_index_o;
  logic [CNT_W-1:0]        polyline_number_o;
  logic [CNT_W-1:0]        point_number_o;
  logic                    last_o;

  raster_scoreboard sb;
  int idle_pct;
  int settings;

  octilinear_polyline_raster i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .mode_i           (mode_i),
    .first_of_line_i  (first_of_line_i),
    .x_i              (x_i),
    .y_i              (y_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .res_valid_o      (res_valid_o),
    .kind_o           (kind_o),
    .row_bits_o       (row_bits_o),
    .row_index_o      (row_index_o),
    .polyline_number_o(polyline_number_o),
    .point_number_o   (point_number_o),
    .last_o           (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o !== 1'b0)
      sb.check_result(kind_o, row_bits_o, row_index_o, polyline_number_o,
                      point_number_o, last_o);
  end

  task automatic send(logic mode, logic first, logic [CRD_W-1:0] x, logic [CRD_W-1:0] y);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start           <= 1'b1;
    mode_i          <= mode;
    first_of_line_i <= first;
    x_i             <= x;
    y_i             <= y;
    do @(posedge clk_i); while (busy);
    sb.note_request(mode, first, x, y);
  endtask

  task automatic vertex(logic first, int x, int y);
    send(OP_VERTEX, first, CRD_W'(x), CRD_W'(y));
  endtask

  task automatic finish_frame();
    send(OP_FINISH, 1'($urandom_range(1)), CRD_W'($urandom), CRD_W'($urandom));
  endtask

  // lets the block drain before a register write
  task automatic quiesce();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_grid(int rows, int cols);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_GRID_ROWS;
    cfg_data_i  <= EXT_W'(rows);
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_register(REG_GRID_ROWS, EXT_W'(rows));
    cfg_index_i <= REG_GRID_COLS;
    cfg_data_i  <= EXT_W'(cols);
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_register(REG_GRID_COLS, EXT_W'(cols));
    cfg_valid_i <= 1'b0;
    settings++;
  endtask

  // range of step counts along (s) that keeps coordinate p inside [0, ext)
  function automatic void clamp_span(int p, int s, int ext, inout int lo, inout int hi);
    if (s == 0) begin
      if (p < 0 || p >= ext) hi = -1;
    end else if (s > 0) begin
      lo = (lo > -p) ? lo : -p;
      hi = (hi < ext - 1 - p) ? hi : ext - 1 - p;
    end else begin
      lo = (lo > p - ext + 1) ? lo : p - ext + 1;
      hi = (hi < p) ? hi : p;
    end
  endfunction

  task automatic random_polylines(int n);
    int sent, rows, cols, sx, sy, lo, hi, len, tries;
    rows = sb.rows_eff();
    cols = sb.cols_eff();
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(99) < 3) begin
        send(1'($urandom_range(1)), 1'($urandom_range(1)), CRD_W'($urandom),
             CRD_W'($urandom));
        sent++;
      end else if ($urandom_range(99) < 13) begin
        finish_frame();
        sent++;
      end else begin
        if ($urandom_range(99) < 85)
          vertex(1'b1, $urandom_range(cols - 1), $urandom_range(rows - 1));
        else
          vertex(1'b1, int'($urandom_range(cols + 39)) - 20,
                 int'($urandom_range(rows + 39)) - 20);
        sent++;
        repeat ($urandom_range(6, 1)) begin
          if ($urandom_range(199) < 3) begin
            case ($urandom_range(2))
              0: vertex(1'b0, sb.prev_x + 1, sb.prev_y + 2);
              1: vertex(1'b0, cols + int'($urandom_range(900)), sb.prev_y);
              default: vertex(1'b0, sb.prev_x, -1 - int'($urandom_range(1000)));
            endcase
          end else begin
            tries = 0;
            do begin
              sx = int'($urandom_range(2)) - 1;
              sy = int'($urandom_range(2)) - 1;
              lo = 0;
              hi = 2047;
              clamp_span(sb.prev_x, sx, cols, lo, hi);
              clamp_span(sb.prev_y, sy, rows, lo, hi);
              tries++;
            end while (lo > hi && tries < 8);
            if (lo <= hi) begin
              len = $urandom_range(hi, lo);
              vertex(1'b0, sb.prev_x + len * sx, sb.prev_y + len * sy);
            end else begin
              vertex(1'b0, $urandom_range(cols - 1), $urandom_range(rows - 1));
            end
          end
          sent++;
        end
      end
    end
  endtask

  initial begin
    int ph_rows[NUM_PHASES] = '{64, 127, 1, 0, 17, 2, 65};
    int ph_cols[NUM_PHASES] = '{64, 100, 1, 0, 40, 64, 3};
    int ph_idle[NUM_PHASES] = '{0, 88, 0, 13, 88, 0, 13};
    sb = new();
    idle_pct = 0;
    settings = 1;
    rst_ni          <= 1'b0;
    start           <= 1'b0;
    mode_i          <= OP_VERTEX;
    first_of_line_i <= 1'b0;
    x_i             <= '0;
    y_i             <= '0;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= REG_GRID_ROWS;
    cfg_data_i      <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // segment from the reset origin, then horizontal, vertical and both diagonal segments across the full grid
    vertex(1'b0, 3, 3);
    vertex(1'b1, 0, 0);
    vertex(1'b0, 0, 63);
    vertex(1'b0, 63, 63);
    vertex(1'b0, 0, 0);
    vertex(1'b0, 63, 0);
    vertex(1'b0, 0, 63);
    vertex(1'b0, 0, 63);
    // clipped segments starting outside the grid
    vertex(1'b1, -1024, -1024);
    vertex(1'b0, 10, 10);
    vertex(1'b1, -10, 70);
    vertex(1'b0, 5, 55);
    finish_frame();
    // error before any first vertex, ignored vertices, finish after an error, then direction and grid errors
    vertex(1'b0, 1023, 1023);
    vertex(1'b0, 2, 2);
    vertex(1'b1, 1023, -1024);
    finish_frame();
    vertex(1'b1, 0, 0);
    vertex(1'b0, 1, 2);
    finish_frame();
    vertex(1'b1, 1, 1);
    vertex(1'b0, -1, 1);
    finish_frame();
    vertex(1'b1, 0, 0);
    vertex(1'b0, 0, 64);
    finish_frame();
    quiesce();

    for (int p = 0; p < NUM_PHASES; p++) begin
      quiesce();
      set_grid(ph_rows[p], ph_cols[p]);
      idle_pct = ph_idle[p];
      random_polylines(ITEMS_PER_PHASE);
    end
    idle_pct = 0;
    finish_frame();
    quiesce();

    $display("%0d requests under %0d grid settings, %0d bitmap rows and %0d error reports seen",
             sb.requests, settings, sb.rows_seen, sb.reports_seen);
    $display("%0d mismatches, %0d results still awaited", sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_octilinear_polyline_raster: clean");
    end else begin
      $display("tb_octilinear_polyline_raster: errors");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("tb_octilinear_polyline_raster: errors");
    $finish;
  end

endmodule
